### rtl/kwl_pkg.sv
// ----------------------------------------------------------------------------
// kwl_pkg: shared definitions for the keyword token lexer
// Character codes, item kinds, register indexes, quote states and defaults.
// ----------------------------------------------------------------------------
package kwl_pkg;

   localparam int DEF_BUF_DEPTH    = 1024;
   localparam int DEF_MAX_WORDS    = 16;
   localparam int DEF_MAX_WORD_LEN = 16;

   localparam int LIMIT_W    = 11;
   localparam int COUNT_W    = 5;
   localparam int CODE_W     = 4;
   localparam int FILL_OUT_W = 11;
   localparam int CHAR_W     = 8;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

   localparam logic [1:0] KIND_CHAR  = 2'd0;
   localparam logic [1:0] KIND_LOAD  = 2'd1;
   localparam logic [1:0] KIND_FLUSH = 2'd2;

   localparam logic [1:0] REG_BUFFER_LIMIT = 2'd0;
   localparam logic [1:0] REG_WORD_COUNT   = 2'd1;

   localparam logic [CHAR_W-1:0] CH_SEMI    = 8'h3B;
   localparam logic [CHAR_W-1:0] CH_SLASH   = 8'h2F;
   localparam logic [CHAR_W-1:0] CH_STAR    = 8'h2A;
   localparam logic [CHAR_W-1:0] CH_NL      = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
   localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
   localparam logic [CHAR_W-1:0] CH_DQUOTE  = 8'h22;
   localparam logic [CHAR_W-1:0] CH_SQUOTE  = 8'h27;

   typedef enum logic [1:0] {
      Q_OUT = 2'd0,
      Q_DBL = 2'd1,
      Q_SGL = 2'd2
   } quote_type;

endpackage

### rtl/kwl_ram.sv
// ----------------------------------------------------------------------------
// kwl_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module kwl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/keyword_token_lexer_core.sv
// ----------------------------------------------------------------------------
// keyword_token_lexer_core: longest-prefix keyword tokenizer
// Buffers a character stream up to ';' and reports the longest loaded
// keyword that prefixes the token, with comment and quote handling.
// ----------------------------------------------------------------------------
// Load, flush and non-';' character words give their result in the cycle after
// acceptance. A terminating ';' scans n active keywords, one per cycle through
// the per-position keyword RAMs (registered read); no word is taken meanwhile.
// Throughput: one word per cycle while the response is taken and no scan runs.
// Reset: synchronous; clears control state and keyword valid bits, so the
// keyword table reads as all zero right after reset with no clearing pass.
module keyword_token_lexer_core #(
   parameter int BUF_DEPTH    = kwl_pkg::DEF_BUF_DEPTH,
   parameter int MAX_WORDS    = kwl_pkg::DEF_MAX_WORDS,
   parameter int MAX_WORD_LEN = kwl_pkg::DEF_MAX_WORD_LEN
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // char_value, word_index, char_pos
   input  logic [1:0]  req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // token_code, parse_error, buffer_full,
                                    // inside_quote, fill
   output logic        rsp_tuser,   // token_valid
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_data
);
   import kwl_pkg::*;

   localparam int FW  = $clog2(BUF_DEPTH + 1);
   localparam int CW  = FW > LIMIT_W ? FW : LIMIT_W;
   localparam int HL  = MAX_WORD_LEN > 2 ? MAX_WORD_LEN : 2;
   localparam int HIW = $clog2(HL);
   localparam int IW  = MAX_WORDS > 1 ? $clog2(MAX_WORDS) : 1;
   localparam int NW  = $clog2(MAX_WORDS + 1);
   localparam int NCW = NW > COUNT_W ? NW : COUNT_W;
   localparam int PW  = MAX_WORD_LEN > 1 ? $clog2(MAX_WORD_LEN) : 1;
   localparam int LW  = $clog2(MAX_WORD_LEN + 1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   state_type            state_ff,    state_in;
   logic [LIMIT_W-1:0]   limit_ff,    limit_in;
   logic [COUNT_W-1:0]   count_ff,    count_in;
   logic [FW-1:0]        fill_ff,     fill_in;
   quote_type            quote_ff,    quote_in;
   logic                 err_ff,      err_in;
   logic [CHAR_W-1:0]    last1_ff,    last1_in;
   logic [CHAR_W-1:0]    last2_ff,    last2_in;
   logic [CHAR_W-1:0]    head_ff [HL];
   logic [CHAR_W-1:0]    head_in [HL];
   logic [NW-1:0]        iss_ff,      iss_in;
   logic                 pend_ff,     pend_in;
   logic [IW-1:0]        pend_idx_ff, pend_idx_in;
   logic [LW-1:0]        best_len_ff, best_len_in;
   logic [IW-1:0]        best_idx_ff, best_idx_in;
   logic                 found_ff,    found_in;
   logic [FW-1:0]        tok_len_ff,  tok_len_in;
   logic [MAX_WORDS-1:0][MAX_WORD_LEN-1:0] kw_valid_ff, kw_valid_in;
   logic [MAX_WORD_LEN-1:0] vrow_ff,  vrow_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_hit_ff,   rsp_hit_in;
   logic [CODE_W-1:0]    rsp_code_ff,  rsp_code_in;

   logic [1:0]           in_kind;
   logic [CHAR_W-1:0]    in_char;
   logic [3:0]           in_widx;
   logic [3:0]           in_cpos;
   logic                 accept;
   logic [CW-1:0]        lim_eff;

   logic [MAX_WORD_LEN-1:0] ram_we;
   logic [IW-1:0]        ram_waddr;
   logic [IW-1:0]        ram_raddr;
   logic [CHAR_W-1:0]    ram_rdata [MAX_WORD_LEN];

   logic [CHAR_W-1:0]    kw_byte [MAX_WORD_LEN];
   logic [LW-1:0]        kw_len;
   logic                 kw_hit;

   assign in_kind = req_tuser;
   assign in_char = req_tdata[7:0];
   assign in_widx = req_tdata[11:8];
   assign in_cpos = req_tdata[15:12];

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign lim_eff = (CW'(limit_ff) > CW'(BUF_DEPTH)) ? CW'(BUF_DEPTH) : CW'(limit_ff);

   assign ram_raddr = iss_ff[IW-1:0];
   assign ram_waddr = IW'(in_widx);

   for (genvar p = 0; p < MAX_WORD_LEN; p++) begin : g_kw_ram
      kwl_ram #(
         .WIDTH (CHAR_W),
         .DEPTH (MAX_WORDS)
      ) u_kw_ram (
         .clock   (clock),
         .wr_en   (ram_we[p]),
         .wr_addr (ram_waddr),
         .wr_data (in_char),
         .rd_addr (ram_raddr),
         .rd_data (ram_rdata[p])
      );
   end

   // keyword compare against the registered token head
   always_comb begin
      logic mism;
      mism   = 1'b0;
      kw_len = LW'(MAX_WORD_LEN);
      for (int k = 0; k < MAX_WORD_LEN; k++) begin
         kw_byte[k] = vrow_ff[k] ? ram_rdata[k] : CH_NUL;
      end
      for (int k = MAX_WORD_LEN - 1; k >= 0; k--) begin
         if (kw_byte[k] == CH_NUL) begin
            kw_len = LW'(k);
         end
      end
      for (int k = 0; k < MAX_WORD_LEN; k++) begin
         if ((LW'(k) < kw_len) && (head_ff[k] != kw_byte[k])) begin
            mism = 1'b1;
         end
      end
      kw_hit = (kw_len != '0) && (CW'(kw_len) <= CW'(tok_len_ff)) && !mism &&
               (kw_len > best_len_ff);
   end

   always_comb begin
      logic [FW-1:0]  fill_c;
      logic [CW-1:0]  fill_w;
      logic           err_c;
      quote_type      quote_c;
      logic           go;
      logic           store;
      logic           start;
      logic           line_cmt;
      logic           blk_cmt;
      logic           load_ok;
      logic           issue;
      logic [NCW-1:0] n_eff;

      state_in    = state_ff;
      limit_in    = limit_ff;
      count_in    = count_ff;
      fill_in     = fill_ff;
      quote_in    = quote_ff;
      err_in      = err_ff;
      last1_in    = last1_ff;
      last2_in    = last2_ff;
      head_in     = head_ff;
      iss_in      = iss_ff;
      pend_in     = pend_ff;
      pend_idx_in = pend_idx_ff;
      best_len_in = best_len_ff;
      best_idx_in = best_idx_ff;
      found_in    = found_ff;
      tok_len_in  = tok_len_ff;
      kw_valid_in = kw_valid_ff;
      vrow_in     = vrow_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_hit_in  = rsp_hit_ff;
      rsp_code_in = rsp_code_ff;
      ram_we      = '0;

      fill_c  = fill_ff;
      err_c   = err_ff;
      quote_c = quote_ff;
      go      = 1'b1;
      store   = 1'b0;
      start   = 1'b0;
      issue   = 1'b0;

      line_cmt = (fill_ff >= FW'(2)) && (head_ff[0] == CH_SLASH) && (head_ff[1] == CH_SLASH);
      blk_cmt  = (fill_ff >= FW'(2)) && (head_ff[0] == CH_SLASH) && (head_ff[1] == CH_STAR);
      load_ok  = (int'(in_widx) < MAX_WORDS) && (int'(in_cpos) < MAX_WORD_LEN);
      n_eff    = (NCW'(count_ff) > NCW'(MAX_WORDS)) ? NCW'(MAX_WORDS) : NCW'(count_ff);

      if (csr_valid) begin
         case (csr_index)
            REG_BUFFER_LIMIT: limit_in = csr_data;
            REG_WORD_COUNT:   count_in = csr_data[COUNT_W-1:0];
            default: ;
         endcase
      end

      // character path
      if (line_cmt) begin
         go = 1'b0;
         if ((in_char == CH_NL) || (in_char == CH_CR)) begin
            fill_c = '0;
            err_c  = 1'b0;
         end
      end else if (blk_cmt) begin
         if ((last2_ff == CH_STAR) && (last1_ff == CH_SLASH)) begin
            fill_c = '0;
            err_c  = 1'b0;
         end else if ((in_char != CH_STAR) && (in_char != CH_SLASH)) begin
            go = 1'b0;
         end
      end
      fill_w = CW'(fill_c);
      if (go && (fill_w < lim_eff)) begin
         if (fill_c != '0) begin
            if (last1_ff == CH_DQUOTE) begin
               if (quote_c == Q_DBL) quote_c = Q_OUT;
               else if (quote_c == Q_OUT) quote_c = Q_DBL;
            end
            if (last1_ff == CH_SQUOTE) begin
               if (quote_c == Q_SGL) quote_c = Q_OUT;
               else if (quote_c == Q_OUT) quote_c = Q_SGL;
            end
         end
         if ((quote_c == Q_OUT) &&
             (in_char inside {CH_NL, CH_CR, CH_TAB, CH_NUL, CH_SPACE})) begin
            store = 1'b0;
         end else if ((quote_c == Q_OUT) && (in_char == CH_SEMI)) begin
            start = 1'b1;
         end else if (fill_w < CW'(BUF_DEPTH)) begin
            store = 1'b1;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = 1'b0;
               rsp_code_in  = '0;
               case (in_kind)
                  KIND_CHAR: begin
                     fill_in  = fill_c;
                     err_in   = err_c;
                     quote_in = quote_c;
                     if (store) begin
                        if (fill_w < CW'(HL)) begin
                           head_in[fill_w[HIW-1:0]] = in_char;
                        end
                        last2_in = last1_ff;
                        last1_in = in_char;
                        fill_in  = fill_c + FW'(1);
                     end
                     if (start) begin
                        rsp_valid_in = 1'b0;
                        tok_len_in   = fill_c;
                        fill_in      = '0;
                        iss_in       = '0;
                        pend_in      = 1'b0;
                        found_in     = 1'b0;
                        best_len_in  = '0;
                        best_idx_in  = '0;
                        state_in     = ST_SCAN;
                     end
                  end
                  KIND_LOAD: begin
                     if (load_ok) begin
                        for (int p = 0; p < MAX_WORD_LEN; p++) begin
                           ram_we[p] = (int'(in_cpos) == p);
                        end
                        kw_valid_in[IW'(in_widx)][PW'(in_cpos)] = 1'b1;
                     end
                  end
                  KIND_FLUSH: begin
                     fill_in = '0;
                     err_in  = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            issue = NCW'(iss_ff) < n_eff;
            if (issue) begin
               iss_in      = iss_ff + NW'(1);
               pend_idx_in = iss_ff[IW-1:0];
               vrow_in     = kw_valid_ff[ram_raddr];
            end
            pend_in = issue;
            if (pend_ff && kw_hit) begin
               best_len_in = kw_len;
               best_idx_in = pend_idx_ff;
               found_in    = 1'b1;
            end
            if (!issue && !pend_ff) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = found_ff;
               rsp_code_in  = found_ff ? CODE_W'(best_idx_ff) : '0;
               if (!found_ff) begin
                  err_in = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         limit_ff     <= LIMIT_RESET;
         count_ff     <= '0;
         fill_ff      <= '0;
         quote_ff     <= Q_OUT;
         err_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         found_ff     <= 1'b0;
         kw_valid_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         count_ff     <= count_in;
         fill_ff      <= fill_in;
         quote_ff     <= quote_in;
         err_ff       <= err_in;
         pend_ff      <= pend_in;
         found_ff     <= found_in;
         kw_valid_ff  <= kw_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      last1_ff    <= last1_in;
      last2_ff    <= last2_in;
      head_ff     <= head_in;
      iss_ff      <= iss_in;
      pend_idx_ff <= pend_idx_in;
      best_len_ff <= best_len_in;
      best_idx_ff <= best_idx_in;
      tok_len_ff  <= tok_len_in;
      vrow_ff     <= vrow_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_code_ff <= rsp_code_in;
   end

   // while a word waits, only buffer_full can move (limit writes)
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_hit_ff;
   assign rsp_tdata  = {6'b0, FILL_OUT_W'(fill_ff), (quote_ff != Q_OUT),
                        (CW'(fill_ff) >= lim_eff), err_ff, rsp_code_ff};

endmodule
